// ===== hdl/rcsa_pkg.sv =====
// ----------------------------------------------------------------------------
// rcsa_pkg
// Shared types, constants and helpers of the rotating command slot allocator.
// ----------------------------------------------------------------------------
package rcsa_pkg;

	localparam int MAX_SLOTS = 64;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

	// scan tree: groups of eight slots, first level registered
	localparam int GRP_SZ   = 8;
	localparam int GRP_SZ_W = 3;
	localparam int GRP_N    = (MAX_SLOTS + GRP_SZ - 1) / GRP_SZ;
	localparam int GRP_IW   = (GRP_N > 1) ? $clog2(GRP_N) : 1;
	localparam int PAD_N    = GRP_N * GRP_SZ;
	localparam int PAD_W    = $clog2(PAD_N);

	localparam int CFG_CNT_W = 7;
	localparam int CFG_OFS_W = 16;
	localparam int REL_W     = 6;
	localparam int IDX_W     = 6;
	localparam int CID_W     = 16;

	// register map index (paddr[2])
	localparam logic REG_SLOTS  = 1'b0;
	localparam logic REG_OFFSET = 1'b1;

	// item kinds
	localparam logic KIND_ALLOC   = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	// result status codes
	localparam logic [1:0] STAT_GRANTED  = 2'd0;
	localparam logic [1:0] STAT_NOFREE   = 2'd1;
	localparam logic [1:0] STAT_RELEASED = 2'd2;

	typedef struct packed {
		logic             kind;
		logic [REL_W-1:0] release_index;
	} item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] slot_index;
		logic [CID_W-1:0] command_id;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // latch item, slot count and start pointer
		logic grp;     // evaluate per-group free search
		logic pick;    // select slot, update marks and pointer, emit result
		logic rel;     // clear mark, emit release result
	} cmd_t;

	// lowest set bit of an 8-bit vector
	function automatic logic [GRP_SZ_W-1:0] first_set8(input logic [GRP_SZ-1:0] v);
		logic [GRP_SZ_W-1:0] r;
		r = '0;
		for (int b = GRP_SZ - 1; b >= 0; b--) begin
			if (v[b]) begin
				r = GRP_SZ_W'(b);
			end
		end
		return r;
	endfunction

endpackage

// ===== hdl/rotating_command_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// rotating_command_slot_allocator
// Round-robin command slot allocator with APB configuration registers.
// ----------------------------------------------------------------------------
//
// Channel   Handshake                 Payload
// --------  ------------------------  ---------------------------------------
// command   start & !busy             item   (kind, release_index)
// result    done (one-cycle strobe)   result (status, slot_index, command_id)
// config    psel & penable & pwrite   pwdata -> reg paddr[2] (0 count, 1 ofs)
//
// Allocate steps: latch, per-group search over eight-slot groups, then group
// select and mark update; release steps: latch, then mark clear.
// A new transaction is accepted in the cycle the done strobe is shown; no new
// command is taken while busy, so one transaction finishes before the next.
// Reset: all slots free, pointer at slot 0, slot count 64, offset 0.
// The receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
module rotating_command_slot_allocator import rcsa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// command transaction
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	// result transaction
	output logic        done,
	output result_t     result,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [CFG_CNT_W-1:0] slots_cfg_q;
	logic [CFG_OFS_W-1:0] offset_cfg_q;
	logic                 cfg_wr;
	cmd_t                 cmd;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_cfg_q  <= CFG_CNT_W'(64);
			offset_cfg_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_SLOTS) begin
				slots_cfg_q <= pwdata[CFG_CNT_W-1:0];
			end else begin
				offset_cfg_q <= pwdata[CFG_OFS_W-1:0];
			end
		end
	end

	// register readback
	always_comb begin
		if (paddr[2] == REG_OFFSET) begin
			prdata = 32'(offset_cfg_q);
		end else begin
			prdata = 32'(slots_cfg_q);
		end
	end

	rcsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (item.kind),
		.busy   (busy),
		.cmd    (cmd)
	);

	rcsa_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.item       (item),
		.slots_cfg  (slots_cfg_q),
		.offset_cfg (offset_cfg_q),
		.result     (result),
		.done       (done)
	);

endmodule

// ===== hdl/rcsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcsa_ctrl
// Sequencer: accepts a transaction and steps the datapath through it.
// ----------------------------------------------------------------------------
module rcsa_ctrl import rcsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic kind,
	output logic busy,
	output cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_GRP  = 2'd1;
	localparam logic [1:0] ST_PICK = 2'd2;
	localparam logic [1:0] ST_REL  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.load = (state_q == ST_IDLE) && start;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (kind == KIND_RELEASE) ? ST_REL : ST_GRP;
				end
			end
			ST_GRP: begin
				cmd.grp = 1'b1;
				state_d = ST_PICK;
			end
			ST_PICK: begin
				cmd.pick = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_REL: begin
				cmd.rel = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/rcsa_dp.sv =====
// ----------------------------------------------------------------------------
// rcsa_dp
// Datapath: busy marks, rotating pointer, two-level free-slot search, result.
// ----------------------------------------------------------------------------
module rcsa_dp import rcsa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	input  item_t                item,
	input  logic [CFG_CNT_W-1:0] slots_cfg,
	input  logic [CFG_OFS_W-1:0] offset_cfg,
	output result_t              result,
	output logic                 done
);

	logic [MAX_SLOTS-1:0] busy_q;
	logic [SLOT_W-1:0]    scan_start_q;

	// latched transaction
	logic [REL_W-1:0]  rel_q;
	logic [CNT_W-1:0]  n_q;
	logic [SLOT_W-1:0] p_q;

	// group search results
	logic [GRP_N-1:0]    hi_any_s1;
	logic [GRP_N-1:0]    lo_any_s1;
	logic [GRP_SZ_W-1:0] hi_first_s1 [GRP_N];
	logic [GRP_SZ_W-1:0] lo_first_s1 [GRP_N];

	result_t result_q;
	logic    done_q;

	assign result = result_q;
	assign done   = done_q;

	// effective slot count, saturated
	logic [CNT_W-1:0]  n_eff;
	logic [SLOT_W-1:0] p_eff;

	always_comb begin
		if (32'(slots_cfg) > 32'(MAX_SLOTS)) begin
			n_eff = CNT_W'(MAX_SLOTS);
		end else begin
			n_eff = CNT_W'(slots_cfg);
		end
		// pointer past a lowered count restarts at slot 0
		p_eff = (32'(scan_start_q) >= 32'(n_eff)) ? '0 : scan_start_q;
	end

	// first level: free slots at/after pointer (hi) and before it (lo)
	logic [PAD_N-1:0]    free_pad;
	logic [PAD_N-1:0]    hi_vec;
	logic [PAD_N-1:0]    lo_vec;
	logic [GRP_N-1:0]    hi_any;
	logic [GRP_N-1:0]    lo_any;
	logic [GRP_SZ_W-1:0] hi_first [GRP_N];
	logic [GRP_SZ_W-1:0] lo_first [GRP_N];

	always_comb begin
		free_pad = '0;
		free_pad[MAX_SLOTS-1:0] = ~busy_q;
		for (int i = 0; i < PAD_N; i++) begin
			hi_vec[i] = free_pad[i] && (32'(i) >= 32'(p_q)) && (32'(i) < 32'(n_q));
			lo_vec[i] = free_pad[i] && (32'(i) < 32'(p_q));
		end
		for (int g = 0; g < GRP_N; g++) begin
			hi_any[g]   = |hi_vec[g*GRP_SZ +: GRP_SZ];
			lo_any[g]   = |lo_vec[g*GRP_SZ +: GRP_SZ];
			hi_first[g] = first_set8(hi_vec[g*GRP_SZ +: GRP_SZ]);
			lo_first[g] = first_set8(lo_vec[g*GRP_SZ +: GRP_SZ]);
		end
	end

	// second level: first group with a hit, hi side before lo side
	logic [GRP_IW-1:0] hi_grp;
	logic [GRP_IW-1:0] lo_grp;
	logic              found_hi;
	logic              found;
	logic [PAD_W-1:0]  slot;
	logic [31:0]       slot_nxt;
	logic [SLOT_W-1:0] ptr_nxt;

	always_comb begin
		hi_grp = '0;
		lo_grp = '0;
		for (int g = GRP_N - 1; g >= 0; g--) begin
			if (hi_any_s1[g]) begin
				hi_grp = GRP_IW'(g);
			end
			if (lo_any_s1[g]) begin
				lo_grp = GRP_IW'(g);
			end
		end
		found_hi = |hi_any_s1;
		found    = found_hi || (|lo_any_s1);
		if (found_hi) begin
			slot = PAD_W'(32'(hi_grp) * GRP_SZ + 32'(hi_first_s1[hi_grp]));
		end else begin
			slot = PAD_W'(32'(lo_grp) * GRP_SZ + 32'(lo_first_s1[lo_grp]));
		end
		slot_nxt = 32'(slot) + 32'd1;
		ptr_nxt  = (slot_nxt >= 32'(n_q)) ? '0 : SLOT_W'(slot_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= '0;
			scan_start_q <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= cmd.pick || cmd.rel;
			if (cmd.rel) begin
				for (int i = 0; i < MAX_SLOTS; i++) begin
					if (32'(rel_q) == 32'(i)) begin
						busy_q[i] <= 1'b0;
					end
				end
			end
			if (cmd.pick) begin
				if (found) begin
					scan_start_q <= ptr_nxt;
					for (int i = 0; i < MAX_SLOTS; i++) begin
						if (32'(slot) == 32'(i)) begin
							busy_q[i] <= 1'b1;
						end
					end
				end else if (n_q != '0) begin
					// full turn: pointer back at its start
					scan_start_q <= p_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rel_q <= item.release_index;
			n_q   <= n_eff;
			p_q   <= p_eff;
		end
		if (cmd.grp) begin
			hi_any_s1 <= hi_any;
			lo_any_s1 <= lo_any;
			for (int g = 0; g < GRP_N; g++) begin
				hi_first_s1[g] <= hi_first[g];
				lo_first_s1[g] <= lo_first[g];
			end
		end
		if (cmd.rel) begin
			result_q <= '{status: STAT_RELEASED, slot_index: '0, command_id: '0};
		end else if (cmd.pick) begin
			if (found) begin
				result_q.status     <= STAT_GRANTED;
				result_q.slot_index <= IDX_W'(slot);
				result_q.command_id <= offset_cfg + CID_W'(slot);
			end else begin
				result_q <= '{status: STAT_NOFREE, slot_index: '0, command_id: '0};
			end
		end
	end

endmodule

// ===== tb/sv/tb_rotating_command_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_rotating_command_slot_allocator
// Self-checking bench for the round-robin command slot allocator.
// Allocate and release commands flow through a queue-fed driver. A predictor
// mirrors the busy marks, the rotating scan pointer and both registers, and
// works out the result of each accepted command. A monitor compares every
// result strobe against the oldest prediction. The APB registers are
// rewritten between phases, when the block is idle, over small, full,
// zero and saturated slot counts and wrapping ID offsets.
// ----------------------------------------------------------------------------
module tb_rotating_command_slot_allocator;
	import rcsa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// DUT ports; all inputs start at known values
	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        start   = 1'b0;
	logic        busy;
	item_t       item    = '0;
	logic        done;
	result_t     result;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;

	rotating_command_slot_allocator u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// commands waiting for the driver, and results owed by the DUT
	item_t   queued_requests[$];
	result_t expected_results[$];

	// predictor copy of the allocator state and registers
	logic [MAX_SLOTS-1:0] slot_marks = '0;
	logic [SLOT_W-1:0]    scan_ptr   = '0;
	logic [CFG_CNT_W-1:0] cfg_slots  = 7'd64;
	logic [CFG_OFS_W-1:0] cfg_offset = '0;

	int unsigned idle_left   = 0;
	bit          steady_feed = 1'b0;   // phase with back-to-back commands
	int unsigned mismatch_count = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run (~1.5k commands with long gaps).
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Predictor: applies one accepted command to the mirrored state and
	// returns the result the DUT must produce for it.
	// ------------------------------------------------------------------------
	function automatic result_t allocate_or_release(item_t cmd);
		result_t     r;
		int unsigned n;
		int unsigned p;
		int unsigned k;
		bit          found;
		r = '0;
		if (cmd.kind == KIND_RELEASE) begin
			// any index below MAX_SLOTS is cleared, managed or not
			slot_marks[cmd.release_index] = 1'b0;
			r.status = STAT_RELEASED;
			return r;
		end
		// counts above the slot array saturate
		n = (cfg_slots > MAX_SLOTS) ? MAX_SLOTS : cfg_slots;
		if (n == 0) begin
			// nothing managed: pointer stays put
			r.status = STAT_NOFREE;
			return r;
		end
		// pointer left beyond a lowered count restarts at slot 0
		p = (scan_ptr >= n) ? 0 : scan_ptr;
		found = 1'b0;
		for (k = 0; k < n && !found; k++) begin
			if (!slot_marks[SLOT_W'(p)]) begin
				found = 1'b1;
				r.slot_index = IDX_W'(p);
			end
			// pointer passes every slot it examined
			p = (p + 1 >= n) ? 0 : p + 1;
		end
		// a full fruitless turn lands back on the starting slot
		scan_ptr = SLOT_W'(p);
		if (!found) begin
			r.status = STAT_NOFREE;
			return r;
		end
		slot_marks[r.slot_index] = 1'b1;
		r.status     = STAT_GRANTED;
		r.command_id = CID_W'(r.slot_index) + cfg_offset;
		return r;
	endfunction

	// Idle gap after a transaction: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (steady_feed)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------------
	// Driver: presents queued commands. A transaction completes on an edge
	// with start high and busy low; the prediction is taken right there.
	// start is assigned once per edge so a held command never glitches.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				expected_results.push_back(allocate_or_release(item));
			if (!start || !busy) begin
				if (idle_left > 0) begin
					idle_left--;
					start <= 1'b0;
				end else if (queued_requests.size() > 0) begin
					item  <= queued_requests.pop_front();
					start <= 1'b1;
					idle_left = pick_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: the done strobe lasts one cycle and cannot be held off, so
	// every edge with done high carries exactly one result transaction.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: status %0d slot_index %0d command_id %0d",
					result.status, result.slot_index, result.command_id);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					mismatch_count++;
				end
				if (result.slot_index !== want.slot_index) begin
					$error("slot_index: expected %0d, got %0d",
						want.slot_index, result.slot_index);
					mismatch_count++;
				end
				if (result.command_id !== want.command_id) begin
					$error("command_id: expected %0d, got %0d",
						want.command_id, result.command_id);
					mismatch_count++;
				end
			end
		end
	end

	task automatic queue_item(logic kind, logic [REL_W-1:0] idx);
		item_t cmd;
		cmd.kind          = kind;
		cmd.release_index = idx;
		queued_requests.push_back(cmd);
	endtask

	// APB write: setup cycle, then access until pready. Starts on a fresh
	// edge so back-to-back writes never double-assign psel in one step.
	task automatic write_reg(logic idx, logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_SLOTS)
			cfg_slots = value[CFG_CNT_W-1:0];
		else
			cfg_offset = value[CFG_OFS_W-1:0];
	endtask

	task automatic set_config(int unsigned cnt, int unsigned ofs);
		write_reg(REG_SLOTS, cnt);
		write_reg(REG_OFFSET, ofs);
		@(negedge clk);
	endtask

	// Block is idle once nothing is queued, presented or owed; the pause
	// after that covers the allocate pipeline depth.
	task automatic wait_idle();
		do @(negedge clk);
		while (queued_requests.size() != 0 || start || expected_results.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		int unsigned cnt;
		int unsigned ofs;
		int unsigned eff;
		int unsigned alloc_pct;
		int unsigned i;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset registers (64 slots, offset 0): rotation never reuses a
		// freed slot 0 at once; release of a free slot is a no-op.
		queue_item(KIND_ALLOC, '0);
		queue_item(KIND_ALLOC, '1);
		queue_item(KIND_ALLOC, '0);
		queue_item(KIND_ALLOC, '0);
		queue_item(KIND_RELEASE, 6'd0);
		queue_item(KIND_ALLOC, '0);
		queue_item(KIND_RELEASE, 6'd63);
		queue_item(KIND_RELEASE, 6'd2);
		wait_idle();

		// Three slots, max offset: pointer above the count restarts at 0,
		// command ID wraps, full set answers no-free, release above count.
		set_config(3, 16'hFFFF);
		queue_item(KIND_ALLOC, '0);
		queue_item(KIND_ALLOC, '0);
		queue_item(KIND_ALLOC, '0);
		queue_item(KIND_RELEASE, 6'd3);
		queue_item(KIND_RELEASE, 6'd40);
		wait_idle();

		// Zero slots: every allocate is refused.
		set_config(0, 0);
		queue_item(KIND_ALLOC, '1);
		queue_item(KIND_RELEASE, 6'd63);
		wait_idle();

		// Count above the array saturates; marks kept from earlier phases.
		set_config(127, 100);
		queue_item(KIND_ALLOC, '0);
		queue_item(KIND_ALLOC, '0);
		wait_idle();

		// Random phases: mostly small counts so the set fills and no-free
		// answers are frequent; releases mostly target managed slots.
		for (int ph = 0; ph < 14; ph++) begin
			case (ph % 7)
				0: cnt = $urandom_range(1, 4);
				1: cnt = $urandom_range(5, 12);
				2: cnt = 64;
				3: cnt = $urandom_range(65, 127);
				4: cnt = 0;
				5: cnt = $urandom_range(1, 64);
				default: cnt = $urandom_range(1, 2);
			endcase
			case ($urandom_range(0, 3))
				0: ofs = 0;
				1: ofs = 16'hFFFF;
				2: ofs = 16'hFFFF - $urandom_range(0, 70);
				default: ofs = $urandom_range(0, 16'hFFFF);
			endcase
			eff = (cnt > MAX_SLOTS) ? MAX_SLOTS : cnt;
			alloc_pct = $urandom_range(35, 75);
			steady_feed = (ph % 5 == 2);
			set_config(cnt, ofs);
			for (i = 0; i < 100; i++) begin
				if ($urandom_range(0, 99) < alloc_pct)
					queue_item(KIND_ALLOC, REL_W'($urandom));
				else if (eff > 0 && $urandom_range(0, 3) != 0)
					queue_item(KIND_RELEASE, REL_W'($urandom_range(0, eff - 1)));
				else
					queue_item(KIND_RELEASE, REL_W'($urandom));
			end
			wait_idle();
		end

		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
